FILE: hw/rtl/assert_macros.svh
// Assertion helpers. All of them sample on clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define CLFT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// A condition that must hold in the cycle after the trigger.
`define CLFT_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/clft_pkg.sv
`timescale 1ns / 1ps

package clft_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int IDENT_W         = 29;
  localparam int STD_IDENT_W     = 11;
  localparam int LEN_W           = 4;
  localparam int DATA_W          = 64;
  localparam int SLOT_W          = 4;
  localparam int COUNT_OUT_W     = 5;
  localparam int STATUS_W        = 3;
  localparam int KIND_W          = 2;

  localparam logic [LEN_W-1:0] MAX_DATA_LEN = LEN_W'(8);

  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_UPDATED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_APPENDED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd5;

  typedef struct packed {
    logic               fmt;
    logic [IDENT_W-1:0] ident;
    logic               remote;
    logic [LEN_W-1:0]   len;
    logic [DATA_W-1:0]  data;
  } entry_t;

  // Request travelling along the row of cells.
  typedef struct packed {
    logic                vld;
    logic [KIND_W-1:0]   kind;
    entry_t              frame;
    logic [SLOT_W-1:0]   sel;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } token_t;

endpackage

FILE: hw/rtl/clft_in_if.sv
`timescale 1ns / 1ps

interface clft_in_if import clft_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic               frame_format;
  logic [IDENT_W-1:0] ident;
  logic               remote_flag;
  logic [LEN_W-1:0]   byte_count;
  logic [DATA_W-1:0]  payload;
  logic [SLOT_W-1:0]  slot_index;

  modport source (output valid, kind, frame_format, ident, remote_flag, byte_count,
                  payload, slot_index, input ready);
  modport sink (input valid, kind, frame_format, ident, remote_flag, byte_count,
                payload, slot_index, output ready);
endinterface

FILE: hw/rtl/clft_out_if.sv
`timescale 1ns / 1ps

interface clft_out_if import clft_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [SLOT_W-1:0]      slot;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic                   out_format;
  logic [IDENT_W-1:0]     out_ident;
  logic                   out_remote;
  logic [LEN_W-1:0]       out_byte_count;
  logic [DATA_W-1:0]      out_payload;

  modport source (output valid, status, slot, entry_count, out_format, out_ident,
                  out_remote, out_byte_count, out_payload, input ready);
  modport sink (input valid, status, slot, entry_count, out_format, out_ident,
                out_remote, out_byte_count, out_payload, output ready);
endinterface

FILE: hw/rtl/clft_cell.sv
`timescale 1ns / 1ps

module clft_cell import clft_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  token_t           tok_in,
  input  logic [CNT_W-1:0] count,
  output token_t           tok_out
);

  entry_t entry_r;
  token_t tok_r;
  token_t tok_nxt;
  logic   wr;
  logic   in_range;
  logic   at_count;
  logic   key_hit;
  logic   sel_hit;

  assign in_range = 32'(count) > 32'(IDX);
  assign at_count = 32'(count) == 32'(IDX);
  assign key_hit  = (entry_r.fmt == tok_in.frame.fmt) && (entry_r.ident == tok_in.frame.ident);
  assign sel_hit  = 32'(tok_in.sel) == 32'(IDX);

  always_comb begin
    tok_nxt = tok_in;
    wr      = 1'b0;
    if (tok_in.vld && !tok_in.done) begin
      case (tok_in.kind)
        KIND_STORE: begin
          // Cells below the fill count are searched first, so reaching the
          // cell at the count with no hit means the frame is new.
          if (in_range && key_hit) begin
            wr             = 1'b1;
            tok_nxt.done   = 1'b1;
            tok_nxt.status = ST_UPDATED;
            tok_nxt.slot   = SLOT_W'(IDX);
          end else if (at_count) begin
            wr             = 1'b1;
            tok_nxt.done   = 1'b1;
            tok_nxt.status = ST_APPENDED;
            tok_nxt.slot   = SLOT_W'(IDX);
          end
        end
        KIND_READ: begin
          if (in_range && sel_hit) begin
            tok_nxt.done   = 1'b1;
            tok_nxt.status = ST_READ_OK;
            tok_nxt.frame  = entry_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entry_r <= tok_in.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: hw/rtl/can_latest_frame_table.sv
// Channel | Direction | Carries
// in_ch   | sink      | store, read or clear request with one CAN frame
// out_ch  | source    | status, slot, fill count and the frame read back
//
// A request walks the row of TABLE_DEPTH cells, one cell per cycle, and its result is
// registered in a pending register at the end of the row; the next request is taken
// once that result has moved into the output register.
// A request of kind 3 is taken without making the block busy and gives no result.
// Reset (synchronous, rst_n low) empties the table; entry contents are not cleared.
// A stalled output holds its result while the next request walks the row.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module can_latest_frame_table import clft_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  clft_in_if.sink     in_ch,
  clft_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  token_t                 chain [TABLE_DEPTH+1];
  token_t                 head;
  token_t                 pend_r;
  token_t                 out_r;
  token_t                 out_nxt;
  logic [COUNT_OUT_W-1:0] out_cnt_r;
  logic                   out_vld_r;
  logic                   busy_r;
  logic [CNT_W-1:0]       count_r;
  logic [31:0]            count_ext;
  logic                   accept;
  logic                   move_out;
  logic                   tail_append;

  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;
  assign move_out    = pend_r.vld && (!out_vld_r || out_ch.ready);
  assign tail_append = chain[TABLE_DEPTH].vld && (chain[TABLE_DEPTH].status == ST_APPENDED);

  always_comb begin
    head              = '0;
    head.vld          = accept && (in_ch.kind != KIND_UNUSED);
    head.kind         = in_ch.kind;
    head.frame.fmt    = in_ch.frame_format;
    head.frame.ident  = in_ch.frame_format ? in_ch.ident
                                           : IDENT_W'(in_ch.ident[STD_IDENT_W-1:0]);
    head.frame.remote = in_ch.remote_flag;
    head.frame.len    = (in_ch.byte_count > MAX_DATA_LEN) ? MAX_DATA_LEN : in_ch.byte_count;
    head.frame.data   = in_ch.payload;
    head.sel          = in_ch.slot_index;
    case (in_ch.kind)
      KIND_STORE: head.status = ST_DROPPED;
      KIND_READ: begin
        head.status = ST_READ_EMPTY;
        head.slot   = in_ch.slot_index;
      end
      KIND_CLEAR: begin
        head.status = ST_CLEARED;
        head.done   = 1'b1;
      end
      default: head.status = ST_DROPPED;
    endcase
  end

  assign chain[0] = head;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    clft_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (chain[g]),
      .count   (count_r),
      .tok_out (chain[g+1])
    );
  end

  always_comb begin
    out_nxt = pend_r;
    // Only a successful read reports a frame.
    if (pend_r.status != ST_READ_OK) begin
      out_nxt.frame = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      count_r    <= '0;
      pend_r.vld <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (head.vld) begin
        busy_r <= 1'b1;
      end else if (move_out) begin
        busy_r <= 1'b0;
      end

      if (chain[TABLE_DEPTH].vld) begin
        pend_r <= chain[TABLE_DEPTH];
        if (chain[TABLE_DEPTH].status == ST_APPENDED) begin
          count_r <= count_r + CNT_W'(1);
        end else if (chain[TABLE_DEPTH].status == ST_CLEARED) begin
          count_r <= '0;
        end
      end else if (move_out) begin
        pend_r.vld <= 1'b0;
      end

      if (move_out) begin
        out_r     <= out_nxt;
        out_cnt_r <= count_ext[COUNT_OUT_W-1:0];
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign count_ext = 32'(count_r);

  assign out_ch.valid          = out_vld_r;
  assign out_ch.status         = out_r.status;
  assign out_ch.slot           = out_r.slot;
  assign out_ch.entry_count    = out_cnt_r;
  assign out_ch.out_format     = out_r.frame.fmt;
  assign out_ch.out_ident      = out_r.frame.ident;
  assign out_ch.out_remote     = out_r.frame.remote;
  assign out_ch.out_byte_count = out_r.frame.len;
  assign out_ch.out_payload    = out_r.frame.data;

  `CLFT_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(TABLE_DEPTH))
  `CLFT_ASSERT_ALWAYS(a_tail_busy, !chain[TABLE_DEPTH].vld || busy_r)
  `CLFT_ASSERT_ALWAYS(a_pend_busy, !pend_r.vld || busy_r)
  `CLFT_ASSERT_NEXT(a_append_grows, tail_append, count_r == $past(count_r) + CNT_W'(1))

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import clft_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int KEY_POOL    = 24;
  localparam int RAND_ITEMS  = 1600;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_START  = 4000;
  localparam int HOLD_CYCLES = 500;
  localparam int CALM_FROM   = 15000;
  localparam int CALM_TO     = 25000;
  localparam int DRAIN_WAIT  = 40;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               fmt;
    logic [IDENT_W-1:0] ident;
    logic               remote;
    logic [LEN_W-1:0]   len;
    logic [DATA_W-1:0]  data;
    logic [SLOT_W-1:0]  sel;
  } frame_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [SLOT_W-1:0]      slot;
    logic [COUNT_OUT_W-1:0] count;
    logic                   fmt;
    logic [IDENT_W-1:0]     ident;
    logic                   remote;
    logic [LEN_W-1:0]       len;
    logic [DATA_W-1:0]      data;
  } table_reply_t;

  logic clk;
  logic rst_n;
  int   cyc;
  int   hold_left;
  int   fail_cnt;

  frame_req_t   pending_q[$];
  table_reply_t reply_q[$];
  frame_req_t   cur_req;

  // Shadow copy of the frame table.
  logic               fmt_mem[DEPTH];
  logic [IDENT_W-1:0] ident_mem[DEPTH];
  logic               remote_mem[DEPTH];
  logic [LEN_W-1:0]   len_mem[DEPTH];
  logic [DATA_W-1:0]  data_mem[DEPTH];
  int                 fill_cnt;

  logic               key_fmt[KEY_POOL];
  logic [IDENT_W-1:0] key_id[KEY_POOL];

  clft_in_if  in_ch();
  clft_out_if out_ch();

  can_latest_frame_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic calm_now();
    return (cyc >= CALM_FROM) && (cyc < CALM_TO);
  endfunction

  function automatic logic idle_now();
    return !calm_now() && ($urandom_range(99) < 34);
  endfunction

  function automatic void note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void post_req(input logic [KIND_W-1:0] kind, input logic fmt,
                                   input logic [IDENT_W-1:0] ident, input logic remote,
                                   input logic [LEN_W-1:0] len,
                                   input logic [DATA_W-1:0] data,
                                   input logic [SLOT_W-1:0] sel);
    frame_req_t r;
    r.kind   = kind;
    r.fmt    = fmt;
    r.ident  = ident;
    r.remote = remote;
    r.len    = len;
    r.data   = data;
    r.sel    = sel;
    pending_q.push_back(r);
  endfunction

  // Keys come in pairs that share the low 11 identifier bits but differ in format, so the
  // format flag must take part in the match.
  function automatic void refresh_keys();
    for (int k = 0; k < KEY_POOL; k += 2) begin
      key_fmt[k]   = 1'($urandom_range(1));
      key_id[k]    = key_fmt[k] ? IDENT_W'($urandom)
                                : IDENT_W'($urandom_range(2047));
      key_fmt[k+1] = !key_fmt[k];
      key_id[k+1]  = key_id[k] & IDENT_W'(2047);
    end
  endfunction

  // Works out the reply the table gives for one accepted request.
  function automatic void predict_reply(input frame_req_t r);
    table_reply_t       rep;
    logic [IDENT_W-1:0] key;
    logic [LEN_W-1:0]   dlc;
    int                 hit;
    rep = '0;
    case (r.kind)
      KIND_STORE: begin
        key = r.fmt ? r.ident : (r.ident & IDENT_W'(2047));
        dlc = (r.len > MAX_DATA_LEN) ? MAX_DATA_LEN : r.len;
        hit = -1;
        for (int i = 0; i < fill_cnt; i++) begin
          if (hit < 0 && fmt_mem[i] == r.fmt && ident_mem[i] == key) hit = i;
        end
        if (hit >= 0) begin
          rep.status = ST_UPDATED;
        end else if (fill_cnt < DEPTH) begin
          hit = fill_cnt;
          fill_cnt++;
          rep.status = ST_APPENDED;
        end else begin
          rep.status = ST_DROPPED;
        end
        if (hit >= 0) begin
          fmt_mem[hit]    = r.fmt;
          ident_mem[hit]  = key;
          remote_mem[hit] = r.remote;
          len_mem[hit]    = dlc;
          data_mem[hit]   = r.data;
          rep.slot        = SLOT_W'(hit);
        end
        rep.count = COUNT_OUT_W'(fill_cnt);
        reply_q.push_back(rep);
      end
      KIND_READ: begin
        rep.slot  = r.sel;
        rep.count = COUNT_OUT_W'(fill_cnt);
        if (int'(r.sel) < fill_cnt) begin
          rep.status = ST_READ_OK;
          rep.fmt    = fmt_mem[r.sel];
          rep.ident  = ident_mem[r.sel];
          rep.remote = remote_mem[r.sel];
          rep.len    = len_mem[r.sel];
          rep.data   = data_mem[r.sel];
        end else begin
          rep.status = ST_READ_EMPTY;
        end
        reply_q.push_back(rep);
      end
      KIND_CLEAR: begin
        fill_cnt   = 0;
        rep.status = ST_CLEARED;
        reply_q.push_back(rep);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // One long receiver stall so the block fills up and pushes back on its input.
  always @(posedge clk) begin
    if (cyc == HOLD_START) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_reply(cur_req);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() != 0 && !idle_now()) begin
          cur_req = pending_q.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.kind         <= cur_req.kind;
          in_ch.frame_format <= cur_req.fmt;
          in_ch.ident        <= cur_req.ident;
          in_ch.remote_flag  <= cur_req.remote;
          in_ch.byte_count   <= cur_req.len;
          in_ch.payload      <= cur_req.data;
          in_ch.slot_index   <= cur_req.sel;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    table_reply_t got;
    table_reply_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.slot   = out_ch.slot;
        got.count  = out_ch.entry_count;
        got.fmt    = out_ch.out_format;
        got.ident  = out_ch.out_ident;
        got.remote = out_ch.out_remote;
        got.len    = out_ch.out_byte_count;
        got.data   = out_ch.out_payload;
        if (reply_q.size() == 0) begin
          note_fail($sformatf("unexpected reply status=%0d slot=%0d count=%0d",
                              got.status, got.slot, got.count));
        end else begin
          want = reply_q.pop_front();
          if (got !== want) begin
            note_fail($sformatf({"reply mismatch: exp st=%0d slot=%0d cnt=%0d fmt=%0d ",
                                 "id=%h rtr=%0d len=%0d data=%h / got st=%0d slot=%0d ",
                                 "cnt=%0d fmt=%0d id=%h rtr=%0d len=%0d data=%h"},
                                want.status, want.slot, want.count, want.fmt, want.ident,
                                want.remote, want.len, want.data, got.status, got.slot,
                                got.count, got.fmt, got.ident, got.remote, got.len,
                                got.data));
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && !idle_now();
    end
  end

  initial begin
    int made;
    int pick;
    int k;
    logic [IDENT_W-1:0] id;

    rst_n     = 1'b0;
    cyc       = 0;
    hold_left = 0;
    fail_cnt  = 0;
    fill_cnt  = 0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_STORE;
    in_ch.frame_format = 1'b0;
    in_ch.ident        = '0;
    in_ch.remote_flag  = 1'b0;
    in_ch.byte_count   = '0;
    in_ch.payload      = '0;
    in_ch.slot_index   = '0;
    out_ch.ready       = 1'b0;

    // Directed part: field extremes, masking, saturation, full table, clear.
    post_req(KIND_READ, 1'b0, '0, 1'b0, '0, '0, '0);
    post_req(KIND_STORE, 1'b0, IDENT_W'(11'h7FF), 1'b0, '0, '0, '0);
    post_req(KIND_STORE, 1'b1, '1, 1'b1, '1, '1, '1);
    // A standard identifier with upper bits set masks onto slot 0.
    post_req(KIND_STORE, 1'b0, '1, 1'b1, LEN_W'(9), 64'h0123_4567_89AB_CDEF, '0);
    post_req(KIND_STORE, 1'b1, IDENT_W'(11'h7FF), 1'b0, MAX_DATA_LEN, '1, '0);
    post_req(KIND_STORE, 1'b1, '0, 1'b1, LEN_W'(7), '0, '0);
    post_req(KIND_STORE, 1'b0, '0, 1'b0, LEN_W'(8), 64'h8000_0000_0000_0001, '0);
    post_req(KIND_READ, 1'b0, '0, 1'b0, '0, '0, SLOT_W'(0));
    post_req(KIND_READ, 1'b0, '0, 1'b0, '0, '0, SLOT_W'(1));
    post_req(KIND_NONE, 1'b1, '1, 1'b1, '1, '1, '1);
    for (int i = 5; i < DEPTH; i++) begin
      post_req(KIND_STORE, 1'b1, IDENT_W'(32'h1000 + i), i[0], LEN_W'(i), '1 >> i, '0);
    end
    post_req(KIND_STORE, 1'b1, IDENT_W'(32'h0ABC_DEF0), 1'b0, LEN_W'(3), '0, '0);
    post_req(KIND_STORE, 1'b1, IDENT_W'(32'h1000 + DEPTH - 1), 1'b1, LEN_W'(2), '1, '0);
    post_req(KIND_READ, 1'b0, '0, 1'b0, '0, '0, SLOT_W'(DEPTH - 1));
    post_req(KIND_CLEAR, 1'b0, '0, 1'b0, '0, '0, '0);
    post_req(KIND_READ, 1'b0, '0, 1'b0, '0, '0, SLOT_W'(0));

    // Random part: mostly stores drawn from a small key pool so the table
    // fills, updates and drops; reads of any slot, rare clears, some noise.
    refresh_keys();
    made = 0;
    while (made < RAND_ITEMS) begin
      pick = $urandom_range(999);
      if (pick < 15) begin
        if ($urandom_range(1)) refresh_keys();
        post_req(KIND_CLEAR, 1'($urandom_range(1)), IDENT_W'($urandom),
                 1'($urandom_range(1)), LEN_W'($urandom), {$urandom, $urandom},
                 SLOT_W'($urandom));
        made++;
      end else if (pick < 40) begin
        post_req(KIND_NONE, 1'($urandom_range(1)), IDENT_W'($urandom),
                 1'($urandom_range(1)), LEN_W'($urandom), {$urandom, $urandom},
                 SLOT_W'($urandom));
      end else if (pick < 280) begin
        post_req(KIND_READ, 1'($urandom_range(1)), IDENT_W'($urandom),
                 1'($urandom_range(1)), LEN_W'($urandom), {$urandom, $urandom},
                 SLOT_W'($urandom_range(15)));
        made++;
      end else if (pick < 880) begin
        k  = $urandom_range(KEY_POOL - 1);
        id = key_id[k];
        if (!key_fmt[k]) id = (IDENT_W'($urandom) & ~IDENT_W'(2047)) | id;
        post_req(KIND_STORE, key_fmt[k], id, 1'($urandom_range(1)),
                 LEN_W'($urandom_range(15)), {$urandom, $urandom}, SLOT_W'($urandom));
        made++;
      end else begin
        post_req(KIND_STORE, 1'($urandom_range(1)), IDENT_W'($urandom),
                 1'($urandom_range(1)), LEN_W'($urandom), {$urandom, $urandom},
                 SLOT_W'($urandom));
        made++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_q.size() != 0 || in_ch.valid || reply_q.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
